// ----- rtl/core/thf_pkg.sv -----
// thf_pkg: types and constants shared by the hit finder core
// holds the transaction payloads and the configuration register indexes
// depends on nothing
`default_nettype none

package thf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FACTOR_W = 7;
    localparam int THR_W    = 16;
    localparam int TIME_W   = 24;
    localparam int SUM_W    = 32;
    localparam int LEN_W    = 16;
    localparam int WEIGHT_W = SAMPLE_W + FACTOR_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR    = 1'd1;

    localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd8000;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET    = 7'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] spread;
        logic [15:0]                channel_id;
        logic                       end_of_waveform;
    } t_sample;

    typedef struct packed {
        logic [15:0]                hit_channel;
        logic [TIME_W-1:0]          start_time;
        logic [LEN_W-1:0]           time_over;
        logic signed [SUM_W-1:0]    charge_sum;
        logic signed [SAMPLE_W-1:0] peak_charge;
        logic [TIME_W-1:0]          peak_time;
    } t_hit;

    typedef struct packed {
        logic                       over;
        logic                       eow;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [WEIGHT_W-1:0] weighted;
        logic [TIME_W-1:0]          start;
        logic [15:0]                channel;
    } t_prep;

endpackage

`default_nettype wire

// ----- rtl/core/thf_if.sv -----
// thf_if: valid/ready stream interfaces for samples in and hits out
// depends on thf_pkg for the payload types
`default_nettype none

interface thf_sample_if;
    import thf_pkg::*;

    logic    valid;
    logic    ready;
    t_sample payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface thf_hit_if;
    import thf_pkg::*;

    logic valid;
    logic ready;
    t_hit payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/thf_prep.sv -----
// thf_prep: input register stage, threshold compare, weighting and start time
// owns the sample index; depends on thf_pkg and thf_if
`default_nettype none

module thf_prep #(
    parameter int MAX_SAMPLES = 65536
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    thf_sample_if.sink                     i_in,
    input  wire [thf_pkg::THR_W-1:0]       i_threshold,
    input  wire [thf_pkg::FACTOR_W-1:0]    i_factor,
    input  wire                            i_take,
    output logic                           o_valid,
    output thf_pkg::t_prep                 o_data
);
    import thf_pkg::*;

    localparam int IDX_W = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

    logic                 r_valid;
    t_prep                r_data;
    t_prep                n_data;
    logic [IDX_W-1:0]     r_index;
    logic [IDX_W-1:0]     n_index;
    logic                 accept;
    logic signed [32:0]   lhs;
    logic signed [32:0]   rhs;
    logic [IDX_W+FACTOR_W-1:0] start_full;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        lhs = 33'($signed({i_in.payload.sample, 4'b0000}));
        rhs = $signed({1'b0, i_threshold}) * i_in.payload.spread;
        start_full = r_index * i_factor;

        n_data.over     = lhs > rhs;
        n_data.eow      = i_in.payload.end_of_waveform;
        n_data.sample   = i_in.payload.sample;
        n_data.weighted = i_in.payload.sample * $signed({1'b0, i_factor});
        n_data.start    = TIME_W'(start_full);
        n_data.channel  = i_in.payload.channel_id;

        if (i_in.payload.end_of_waveform || r_index == IDX_LAST) begin
            n_index = '0;
        end else begin
            n_index = r_index + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_index <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_index <= n_index;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- rtl/core/thf_track.sv -----
// thf_track: hit state tracking and the result register
// depends on thf_pkg and thf_if
`default_nettype none

module thf_track (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire thf_pkg::t_prep i_data,
    output logic             o_take,
    thf_hit_if.source        o_out
);
    import thf_pkg::*;

    logic                        r_in_hit;
    logic [TIME_W-1:0]           r_start;
    logic signed [SUM_W-1:0]     r_acc;
    logic [LEN_W-1:0]            r_len;
    logic signed [SAMPLE_W-1:0]  r_peak;
    logic [LEN_W-1:0]            r_off;
    logic                        r_out_valid;
    t_hit                        r_hit;

    logic                        emit;
    logic signed [SUM_W:0]       sum;
    logic signed [SUM_W-1:0]     n_acc;
    t_hit                        n_hit;

    assign o_take = i_valid && (!r_out_valid || o_out.ready);
    assign emit   = !i_data.eow && !i_data.over && r_in_hit;

    always_comb begin
        sum = (SUM_W+1)'(r_acc) + (SUM_W+1)'(i_data.weighted);
        if (sum[SUM_W] != sum[SUM_W-1]) begin
            n_acc = sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_acc = sum[SUM_W-1:0];
        end

        n_hit.hit_channel = i_data.channel;
        n_hit.start_time  = r_start;
        n_hit.time_over   = r_len;
        n_hit.charge_sum  = r_acc;
        n_hit.peak_charge = r_peak;
        n_hit.peak_time   = r_start + TIME_W'(r_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_hit    <= 1'b0;
            r_out_valid <= 1'b0;
            r_start     <= '0;
            r_acc       <= '0;
            r_len       <= '0;
            r_peak      <= '0;
            r_off       <= '0;
        end else begin
            if (o_take) begin
                r_out_valid <= emit;
                if (i_data.eow) begin
                    r_in_hit <= 1'b0;
                end else if (i_data.over && !r_in_hit) begin
                    r_in_hit <= 1'b1;
                    r_start  <= i_data.start;
                    r_acc    <= SUM_W'(i_data.sample);
                    r_len    <= LEN_W'(1);
                    r_peak   <= i_data.sample;
                    r_off    <= '0;
                end else if (i_data.over) begin
                    r_acc <= n_acc;
                    if (i_data.sample > r_peak) begin
                        r_peak <= i_data.sample;
                        r_off  <= r_len;
                    end
                    if (r_len != {LEN_W{1'b1}}) begin
                        r_len <= r_len + 1'b1;
                    end
                end else if (r_in_hit) begin
                    r_in_hit <= 1'b0;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take && emit) begin
            r_hit <= n_hit;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_hit;

    // no result from an item that meets no open hit
    a_no_spurious_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && !r_in_hit) |=> !r_out_valid)
        else $error("result without an open hit");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_hit |-> (r_len != '0))
        else $error("open hit with zero length");

    a_off_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_hit |-> (r_off <= r_len))
        else $error("peak offset beyond hit length");

    a_eow_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_data.eow) |=> (!r_in_hit && !r_out_valid))
        else $error("end of waveform left hit open or emitted");

endmodule

`default_nettype wire

// ----- rtl/core/threshold_hit_finder_core.sv -----
// threshold_hit_finder_core: time-over-threshold hit finder, top level
// holds the configuration registers; depends on thf_pkg, thf_if, thf_prep, thf_track
//
//   port        dir   payload      transaction when
//   i_in        in    t_sample     i_in.valid && i_in.ready
//   o_out       out   t_hit        o_out.valid && o_out.ready
//   i_cfg_*     in    16b data     i_cfg_we high
//
// one sample per cycle sustained unless the result stalls; the hit is valid
// once its closing sample passes the input register and the result register
// synchronous active-low reset clears the hit state, sample index and config
// to threshold 8000 and factor 1
// a stalled result holds the result register; input still flows while the
// input register is free
`default_nettype none

module threshold_hit_finder_core #(
    parameter int MAX_SAMPLES = 65536
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    thf_sample_if.sink                       i_in,
    thf_hit_if.source                        o_out,
    input  wire                              i_cfg_we,
    input  wire [thf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [thf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import thf_pkg::*;

    logic [THR_W-1:0]    r_threshold;
    logic [FACTOR_W-1:0] r_factor;
    logic                prep_valid;
    t_prep               prep_data;
    logic                take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
            r_factor    <= FACTOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_FACTOR:    r_factor    <= i_cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    thf_prep #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_threshold (r_threshold),
        .i_factor    (r_factor),
        .i_take      (take),
        .o_valid     (prep_valid),
        .o_data      (prep_data)
    );

    thf_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .i_data  (prep_data),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
